/* sv/cfpd_pkg.sv */
// shared types, codes and constants for the cue frame parser and dispatcher
package cfpd_pkg;

    // frame layout
    localparam int unsigned CUE_LENGTH    = 20;
    localparam int unsigned POS_W         = 5;
    localparam logic [POS_W-1:0] POS_MAX  = 5'd31;
    localparam logic [POS_W-1:0] POS_START     = 5'd0;
    localparam logic [POS_W-1:0] POS_TYPE_LO   = 5'd6;
    localparam logic [POS_W-1:0] POS_TYPE_HI   = 5'd8;
    localparam logic [POS_W-1:0] POS_DEV_LO    = 5'd9;
    localparam logic [POS_W-1:0] POS_DEV_HI    = 5'd10;
    localparam logic [POS_W-1:0] POS_PCT_LO    = 5'd11;
    localparam logic [POS_W-1:0] POS_PCT_HI    = 5'd13;
    localparam logic [POS_W-1:0] POS_DUR_LO    = 5'd14;
    localparam logic [POS_W-1:0] POS_DUR_HI    = 5'd18;
    localparam logic [POS_W-1:0] POS_END       = POS_W'(CUE_LENGTH - 1);
    localparam logic [POS_W-1:0] POS_FULL      = POS_W'(CUE_LENGTH);

    // characters
    localparam logic [7:0] CH_START = 8'h24;
    localparam logic [7:0] CH_END   = 8'h25;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // three-letter cue types, first letter in the high byte
    localparam logic [23:0] TYPE_MOTOR = 24'h4D4F54;
    localparam logic [23:0] TYPE_RELAY = 24'h52454C;
    localparam logic [23:0] TYPE_LIGHT = 24'h444D58;

    // field widths
    localparam int unsigned DEV_W   = 7;
    localparam int unsigned PCT_W   = 10;
    localparam int unsigned DUR_W   = 17;
    localparam int unsigned LEVEL_W = 10;
    localparam int unsigned CHAN_W  = 10;

    localparam logic [DEV_W-1:0]  RELAY_LIMIT   = 7'd8;
    localparam logic [CHAN_W-1:0] CHAN_COUNT_RST = 10'd512;

    typedef enum logic [1:0] {
        OP_CHAR    = 2'd0,
        OP_END     = 2'd1,
        OP_STOP    = 2'd2,
        OP_RESTART = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        CMD_NONE   = 3'd0,
        CMD_MOTOR  = 3'd1,
        CMD_RELAY  = 3'd2,
        CMD_LIGHT  = 3'd3,
        CMD_STOP   = 3'd4,
        CMD_START  = 3'd5
    } command_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_LEN   = 3'd1,
        ST_BAD_START = 3'd2,
        ST_BAD_END   = 3'd3,
        ST_BAD_TYPE  = 3'd4,
        ST_STOPPED   = 3'd5,
        ST_RANGE     = 3'd6
    } status_t;

    // item leaving the input register
    typedef struct packed {
        logic       valid;
        opcode_t    opcode;
        logic [7:0] char_byte;
    } step_t;

    // what the frame holds so far
    typedef struct packed {
        logic              length_ok;
        logic              start_ok;
        logic              end_ok;
        logic [23:0]       type_chars;
        logic [DEV_W-1:0]  device;
        logic [PCT_W-1:0]  percent;
    } frame_info_t;

endpackage

/* sv/cue_frame_parser_dispatch.sv */
// top level of the show cue frame parser and dispatcher
// One item is taken per clock cycle with no gaps, except while an end, stop or
// restart item is held as told below: each item passes from an input register
// through one frame update or command decision, and results go on into the result
// register. The result register is loaded from the input register when its end,
// stop or restart item moves on. Cue characters give no result. The input
// register keeps taking items while a result waits to be taken; it only holds
// an end, stop or restart item while the result register is full and not being
// read. The lighting channel count resets to 512; the user must write it on the cfg
// channel only while the block is idle, which the block itself does not enforce.
module cue_frame_parser_dispatch (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration: light channel count
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [cfpd_pkg::CHAN_W-1:0] cfg_data,
    // input items
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] char_byte
    input  logic [1:0]  s_axis_tuser,   // [1:0] opcode
    // result items
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [6:0] device, [16:7] level,
                                        // [17] direction, [20:18] status, [23:21] zero
    output logic [2:0]  m_axis_tuser    // [2:0] command
);
    import cfpd_pkg::*;

    logic              in_valid_reg, in_valid_next;
    opcode_t           in_opcode_reg;
    logic [7:0]        in_char_reg;
    logic [CHAN_W-1:0] chan_count_reg;
    logic              out_free;
    logic              advance;
    logic              in_fire;
    step_t             step;
    frame_info_t       info;
    command_t          out_command;
    logic [DEV_W-1:0]  out_device;
    logic [LEVEL_W-1:0] out_level;
    logic              out_direction;
    status_t           out_status;

    // the held item moves on unless it needs the result register and that is full
    assign advance       = in_valid_reg && ((in_opcode_reg == OP_CHAR) || out_free);
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;

    always_comb begin
        if (in_fire) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end else begin
            in_valid_next = in_valid_reg;
        end
    end

    // input item register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            in_opcode_reg <= opcode_t'(s_axis_tuser);
            in_char_reg   <= s_axis_tdata;
        end
    end

    // light channel count register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chan_count_reg <= CHAN_COUNT_RST;
        end else if (cfg_valid && cfg_ready) begin
            chan_count_reg <= cfg_data;
        end
    end

    assign step.valid     = advance;
    assign step.opcode    = in_opcode_reg;
    assign step.char_byte = in_char_reg;

    cfpd_frame u_frame (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .info    (info)
    );

    cfpd_dispatch u_dispatch (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .step          (step),
        .info          (info),
        .chan_count    (chan_count_reg),
        .out_ready     (m_axis_tready),
        .out_free      (out_free),
        .out_valid     (m_axis_tvalid),
        .out_command   (out_command),
        .out_device    (out_device),
        .out_level     (out_level),
        .out_direction (out_direction),
        .out_status    (out_status)
    );

    // result packing
    assign m_axis_tuser = out_command;
    assign m_axis_tdata = {3'b000, out_status, out_direction, out_level, out_device};

endmodule

/* sv/cfpd_frame.sv */
// frame state: position count, marks, type letters and decimal fields
module cfpd_frame (
    input  logic                aclk,
    input  logic                aresetn,
    input  cfpd_pkg::step_t     step,
    output cfpd_pkg::frame_info_t info
);
    import cfpd_pkg::*;

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [1:0]       marks_reg, marks_next;
    logic [23:0]      type_reg, type_next;
    logic [DEV_W-1:0] dev_reg, dev_next;
    logic [PCT_W-1:0] pct_reg, pct_next;
    logic [DUR_W-1:0] dur_reg, dur_next;
    logic [2:0]       ended_reg, ended_next;
    logic [2:0]       seen_reg, seen_next;

    logic             is_digit;
    logic             is_space;
    logic [3:0]       digit;
    logic [DEV_W+3:0] dev_mac;
    logic [PCT_W+3:0] pct_mac;
    logic [DUR_W+3:0] dur_mac;
    logic             in_dev, in_pct, in_dur;

    // character classes and the multiply-by-ten accumulate for each field
    always_comb begin
        is_digit = (step.char_byte >= CH_ZERO) && (step.char_byte <= CH_NINE);
        is_space = (step.char_byte == CH_SPACE);
        digit    = step.char_byte[3:0];
        dev_mac  = ({4'b0, dev_reg} << 3) + ({4'b0, dev_reg} << 1)
                   + {{DEV_W{1'b0}}, digit};
        pct_mac  = ({4'b0, pct_reg} << 3) + ({4'b0, pct_reg} << 1)
                   + {{PCT_W{1'b0}}, digit};
        dur_mac  = ({4'b0, dur_reg} << 3) + ({4'b0, dur_reg} << 1)
                   + {{DUR_W{1'b0}}, digit};
        in_dev   = (pos_reg >= POS_DEV_LO) && (pos_reg <= POS_DEV_HI);
        in_pct   = (pos_reg >= POS_PCT_LO) && (pos_reg <= POS_PCT_HI);
        in_dur   = (pos_reg >= POS_DUR_LO) && (pos_reg <= POS_DUR_HI);
    end

    // next frame state
    always_comb begin
        pos_next   = pos_reg;
        marks_next = marks_reg;
        type_next  = type_reg;
        dev_next   = dev_reg;
        pct_next   = pct_reg;
        dur_next   = dur_reg;
        ended_next = ended_reg;
        seen_next  = seen_reg;
        if (step.valid && step.opcode == OP_END) begin
            pos_next   = '0;
            marks_next = '0;
            type_next  = '0;
            dev_next   = '0;
            pct_next   = '0;
            dur_next   = '0;
            ended_next = '0;
            seen_next  = '0;
        end else if (step.valid && step.opcode == OP_CHAR) begin
            if (pos_reg == POS_START) begin
                if (step.char_byte == CH_START) marks_next[0] = 1'b1;
            end else if (pos_reg >= POS_TYPE_LO && pos_reg <= POS_TYPE_HI) begin
                type_next = {type_reg[15:0], step.char_byte};
            end else if (in_dev) begin
                if (!ended_reg[0]) begin
                    if (is_digit) begin
                        seen_next[0] = 1'b1;
                        dev_next     = dev_mac[DEV_W-1:0];
                    end else if (!(is_space && !seen_reg[0])) begin
                        ended_next[0] = 1'b1;
                    end
                end
            end else if (in_pct) begin
                if (!ended_reg[1]) begin
                    if (is_digit) begin
                        seen_next[1] = 1'b1;
                        pct_next     = pct_mac[PCT_W-1:0];
                    end else if (!(is_space && !seen_reg[1])) begin
                        ended_next[1] = 1'b1;
                    end
                end
            end else if (in_dur) begin
                if (!ended_reg[2]) begin
                    if (is_digit) begin
                        seen_next[2] = 1'b1;
                        dur_next     = dur_mac[DUR_W-1:0];
                    end else if (!(is_space && !seen_reg[2])) begin
                        ended_next[2] = 1'b1;
                    end
                end
            end else if (pos_reg == POS_END) begin
                if (step.char_byte == CH_END) marks_next[1] = 1'b1;
            end
            // position saturates so that overlong frames stay bad length
            if (pos_reg != POS_MAX) pos_next = pos_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            marks_reg <= '0;
            type_reg  <= '0;
            dev_reg   <= '0;
            pct_reg   <= '0;
            dur_reg   <= '0;
            ended_reg <= '0;
            seen_reg  <= '0;
        end else begin
            pos_reg   <= pos_next;
            marks_reg <= marks_next;
            type_reg  <= type_next;
            dev_reg   <= dev_next;
            pct_reg   <= pct_next;
            dur_reg   <= dur_next;
            ended_reg <= ended_next;
            seen_reg  <= seen_next;
        end
    end

    // frame summary for the dispatcher
    always_comb begin
        info.length_ok  = (pos_reg == POS_FULL);
        info.start_ok   = marks_reg[0];
        info.end_ok     = marks_reg[1];
        info.type_chars = type_reg;
        info.device     = dev_reg;
        info.percent    = pct_reg;
    end

endmodule

/* sv/cfpd_dispatch.sv */
// command decision, stopped flag and result register
module cfpd_dispatch (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  cfpd_pkg::step_t           step,
    input  cfpd_pkg::frame_info_t     info,
    input  logic [cfpd_pkg::CHAN_W-1:0] chan_count,
    input  logic                      out_ready,
    output logic                      out_free,
    output logic                      out_valid,
    output cfpd_pkg::command_t        out_command,
    output logic [cfpd_pkg::DEV_W-1:0]   out_device,
    output logic [cfpd_pkg::LEVEL_W-1:0] out_level,
    output logic                      out_direction,
    output cfpd_pkg::status_t         out_status
);
    import cfpd_pkg::*;

    logic                valid_reg, valid_next;
    logic                stopped_reg, stopped_next;
    command_t            command_reg, command_next;
    logic [DEV_W-1:0]    device_reg, device_next;
    logic [LEVEL_W-1:0]  level_reg, level_next;
    logic                direction_reg, direction_next;
    status_t             status_reg, status_next;
    logic                fire;
    logic [DEV_W-1:0]    relay_index;

    assign out_free    = !valid_reg || out_ready;
    assign fire        = step.valid && (step.opcode != OP_CHAR);
    assign relay_index = info.device - 1'b1;

    // decide the result for an end, stop or restart item
    always_comb begin
        command_next   = CMD_NONE;
        device_next    = '0;
        level_next     = '0;
        direction_next = 1'b0;
        status_next    = ST_OK;
        stopped_next   = stopped_reg;
        case (step.opcode)
            OP_STOP: begin
                stopped_next = 1'b1;
                command_next = CMD_STOP;
            end
            OP_RESTART: begin
                stopped_next = 1'b0;
                command_next = CMD_START;
            end
            OP_END: begin
                if (!info.length_ok) begin
                    status_next = ST_BAD_LEN;
                end else if (!info.start_ok) begin
                    status_next = ST_BAD_START;
                end else if (!info.end_ok) begin
                    status_next = ST_BAD_END;
                end else if (info.type_chars == TYPE_MOTOR) begin
                    if (stopped_reg) begin
                        status_next = ST_STOPPED;
                    end else begin
                        command_next   = CMD_MOTOR;
                        device_next    = info.device;
                        level_next     = info.percent;
                        direction_next = 1'b1;
                    end
                end else if (info.type_chars == TYPE_RELAY) begin
                    if (stopped_reg) begin
                        status_next = ST_STOPPED;
                    end else if (info.device == '0 || info.device >= RELAY_LIMIT) begin
                        status_next = ST_RANGE;
                    end else begin
                        // relay outputs are active low
                        command_next = CMD_RELAY;
                        device_next  = relay_index;
                        level_next   = (info.percent != '0) ? LEVEL_W'(0) : LEVEL_W'(1);
                    end
                end else if (info.type_chars == TYPE_LIGHT) begin
                    if (stopped_reg) begin
                        status_next = ST_STOPPED;
                    end else if ({{(CHAN_W-DEV_W){1'b0}}, info.device} >= chan_count) begin
                        status_next = ST_RANGE;
                    end else begin
                        command_next = CMD_LIGHT;
                        device_next  = info.device;
                        level_next   = {{(LEVEL_W-8){1'b0}}, info.percent[7:0]};
                    end
                end else begin
                    status_next = ST_BAD_TYPE;
                end
            end
            default: begin
                command_next = CMD_NONE;
            end
        endcase
    end

    // result valid: set by a new result, cleared once taken
    always_comb begin
        if (fire) begin
            valid_next = 1'b1;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg   <= 1'b0;
            stopped_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            if (fire) stopped_reg <= stopped_next;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (fire) begin
            command_reg   <= command_next;
            device_reg    <= device_next;
            level_reg     <= level_next;
            direction_reg <= direction_next;
            status_reg    <= status_next;
        end
    end

    assign out_valid     = valid_reg;
    assign out_command   = command_reg;
    assign out_device    = device_reg;
    assign out_level     = level_reg;
    assign out_direction = direction_reg;
    assign out_status    = status_reg;

endmodule

/* sv/cfpd_checker.sv */
// port-level checks on the cue frame parser and dispatcher, bound to the top level
module cfpd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic [2:0]  m_axis_tuser
);
    import cfpd_pkg::*;

    // nothing is offered straight after reset
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result offered after reset");

    // a waiting result holds until taken
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("waiting result changed");

    // a new result comes from an accepted item that has passed through the input register
    a_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
        else $error("result without an accepted item");

    // a refusal carries no command, and a command carries ok status
    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |->
            (m_axis_tdata[20:18] == ST_OK) || (m_axis_tuser == CMD_NONE))
        else $error("command with a refusal status");

    // stop and start all carry no device, level or direction
    a_global: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && (m_axis_tuser == CMD_STOP || m_axis_tuser == CMD_START) |->
            m_axis_tdata[17:0] == 18'd0)
        else $error("stop or start all with payload");

endmodule

bind cue_frame_parser_dispatch cfpd_checker u_cfpd_checker (.*);

/* test/testbench.sv */
// self-checking testbench for the show cue frame parser and dispatcher
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import cfpd_pkg::*;

    // slowest correct run: ~1900 items, each with random idle gaps, plus
    // results held by receiver stalls, taken several times over
    localparam int CYCLE_LIMIT = 600000;
    localparam int PHASE_ITEMS = 370;
    localparam int PHASES      = 5;
    localparam int SETTLE      = 8;

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;

    typedef struct {
        opcode_t    op;
        logic [7:0] ch;
    } cue_item_t;

    typedef struct {
        command_t          cmd;
        logic [DEV_W-1:0]  device;
        logic [LEVEL_W-1:0] level;
        logic              dir;
        status_t           st;
    } dispatch_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [CHAN_W-1:0] cfg_data  = '0;

    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata  = '0;   // [7:0] char_byte
    logic [1:0] s_axis_tuser  = '0;   // [1:0] opcode

    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;        // [6:0] device, [16:7] level, [17] direction,
                                      // [20:18] status, [23:21] zero
    logic [2:0]  m_axis_tuser;        // [2:0] command

    // handshakes seen at the last rising edge
    logic s_hs   = 1'b0;
    logic cfg_hs = 1'b0;

    cue_item_t cue_q[$];
    dispatch_t dispatch_q[$];

    int items_sent  = 0;
    int items_taken = 0;
    int errors      = 0;
    int cycle_count = 0;

    int tx_gap = 0, tx_quiet = 0;
    int rx_hold = 0, rx_quiet = 0;

    // predictor state
    logic [CHAN_W-1:0] chan_count;
    logic [POS_W-1:0]  char_pos;
    logic [1:0]        frame_marks;
    logic [23:0]       type_word;
    logic [DEV_W-1:0]  dev_acc;
    logic [PCT_W-1:0]  pct_acc;
    logic [DUR_W-1:0]  dur_acc;
    logic [2:0]        field_ended;
    logic [2:0]        digit_seen;
    logic              halted;

    cue_frame_parser_dispatch DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 aclk = ~aclk;

    // idle length: mostly none, some short, a few long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    // quiet stretches with no idling at all
    task automatic next_idle(inout int quiet, output int gap);
        if (quiet > 0) begin
            quiet--;
            gap = 0;
        end else begin
            gap = idle_len();
            if ($urandom_range(0, 24) == 0) quiet = $urandom_range(20, 80);
        end
    endtask

    function automatic void clear_frame();
        char_pos    = '0;
        frame_marks = '0;
        type_word   = '0;
        dev_acc     = '0;
        pct_acc     = '0;
        dur_acc     = '0;
        field_ended = '0;
        digit_seen  = '0;
    endfunction

    // digit value taken by a numeric field, or -1 when nothing is added
    function automatic int field_digit(int f, logic [7:0] c);
        if (field_ended[f]) return -1;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            digit_seen[f] = 1'b1;
            return int'(c - CH_ZERO);
        end
        if (c == CH_SPACE && !digit_seen[f]) return -1;
        field_ended[f] = 1'b1;
        return -1;
    endfunction

    // one accepted item through the predictor
    task automatic cue_step(opcode_t op, logic [7:0] c);
        dispatch_t r;
        int d;
        r.cmd = CMD_NONE;
        r.device = '0;
        r.level = '0;
        r.dir = 1'b0;
        r.st = ST_OK;
        case (op)
            OP_CHAR: begin
                if (char_pos == POS_START) begin
                    if (c == CH_START) frame_marks[0] = 1'b1;
                end else if (char_pos >= POS_TYPE_LO && char_pos <= POS_TYPE_HI) begin
                    type_word = {type_word[15:0], c};
                end else if (char_pos >= POS_DEV_LO && char_pos <= POS_DEV_HI) begin
                    d = field_digit(0, c);
                    if (d >= 0) dev_acc = DEV_W'(int'(dev_acc) * 10 + d);
                end else if (char_pos >= POS_PCT_LO && char_pos <= POS_PCT_HI) begin
                    d = field_digit(1, c);
                    if (d >= 0) pct_acc = PCT_W'(int'(pct_acc) * 10 + d);
                end else if (char_pos >= POS_DUR_LO && char_pos <= POS_DUR_HI) begin
                    d = field_digit(2, c);
                    if (d >= 0) dur_acc = DUR_W'(int'(dur_acc) * 10 + d);
                end else if (char_pos == POS_END) begin
                    if (c == CH_END) frame_marks[1] = 1'b1;
                end
                if (char_pos != POS_MAX) char_pos = char_pos + 1'b1;
            end
            OP_STOP: begin
                halted = 1'b1;
                r.cmd = CMD_STOP;
            end
            OP_RESTART: begin
                halted = 1'b0;
                r.cmd = CMD_START;
            end
            default: begin
                // end of cue: length, marks, then type
                if (char_pos != POS_FULL) r.st = ST_BAD_LEN;
                else if (!frame_marks[0]) r.st = ST_BAD_START;
                else if (!frame_marks[1]) r.st = ST_BAD_END;
                else if (type_word == TYPE_MOTOR) begin
                    if (halted) r.st = ST_STOPPED;
                    else begin
                        r.cmd = CMD_MOTOR;
                        r.device = dev_acc;
                        r.level = pct_acc;
                        r.dir = 1'b1;
                    end
                end else if (type_word == TYPE_RELAY) begin
                    if (halted) r.st = ST_STOPPED;
                    else if (dev_acc == '0 || dev_acc >= RELAY_LIMIT) r.st = ST_RANGE;
                    else begin
                        r.cmd = CMD_RELAY;
                        r.device = dev_acc - 1'b1;
                        r.level = (pct_acc != '0) ? 10'd0 : 10'd1;
                    end
                end else if (type_word == TYPE_LIGHT) begin
                    if (halted) r.st = ST_STOPPED;
                    else if (CHAN_W'(dev_acc) >= chan_count) r.st = ST_RANGE;
                    else begin
                        r.cmd = CMD_LIGHT;
                        r.device = dev_acc;
                        r.level = {2'b00, pct_acc[7:0]};
                    end
                end else begin
                    r.st = ST_BAD_TYPE;
                end
                clear_frame();
            end
        endcase
        if (op != OP_CHAR) dispatch_q.push_back(r);
    endtask

    task automatic check_field(string what, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0d got %0d", $time, what, want, got);
            errors++;
        end
    endtask

    // monitor, predictor and checker on the rising edge
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("cue_frame_parser_dispatch: mismatch");
            $finish;
        end else begin
            s_hs   <= aresetn && s_axis_tvalid && s_axis_tready;
            cfg_hs <= aresetn && cfg_valid && cfg_ready;
            if (!aresetn) begin
                chan_count = CHAN_COUNT_RST;
                halted = 1'b0;
                clear_frame();
            end else begin
                if (cfg_valid && cfg_ready) chan_count = cfg_data;
                if (s_axis_tvalid && s_axis_tready) begin
                    items_taken++;
                    cue_step(opcode_t'(s_axis_tuser), s_axis_tdata);
                end
                if (m_axis_tvalid && m_axis_tready) begin
                    if (dispatch_q.size() == 0) begin
                        $display("%0t: unexpected result, command %0d tdata %h",
                                 $time, m_axis_tuser, m_axis_tdata);
                        errors++;
                    end else begin
                        dispatch_t e;
                        e = dispatch_q.pop_front();
                        check_field("command", 32'(e.cmd), 32'(m_axis_tuser));
                        check_field("device", 32'(e.device), 32'(m_axis_tdata[6:0]));
                        check_field("level", 32'(e.level), 32'(m_axis_tdata[16:7]));
                        check_field("direction", 32'(e.dir), 32'(m_axis_tdata[17]));
                        check_field("status", 32'(e.st), 32'(m_axis_tdata[20:18]));
                        check_field("padding", 32'd0, 32'(m_axis_tdata[23:21]));
                    end
                end
            end
        end
    end

    // input driver, fed from the pending item queue
    always @(negedge aclk) begin
        if (aresetn && (!s_axis_tvalid || s_hs)) begin
            if (tx_gap > 0) begin
                tx_gap--;
                s_axis_tvalid <= 1'b0;
            end else if (cue_q.size() != 0) begin
                cue_item_t it;
                it = cue_q.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= it.ch;
                s_axis_tuser  <= it.op;
                next_idle(tx_quiet, tx_gap);
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // result side stalls
    always @(negedge aclk) begin
        if (aresetn) begin
            if (rx_hold == 0) next_idle(rx_quiet, rx_hold);
            if (rx_hold > 0) begin
                rx_hold--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic add_item(opcode_t op, logic [7:0] c);
        cue_item_t it;
        it.op = op;
        it.ch = c;
        cue_q.push_back(it);
        items_sent++;
    endtask

    // character of a numeric field: digits mostly, with spaces, signs and junk
    function automatic logic [7:0] num_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return CH_ZERO + 8'($urandom_range(0, 9));
        if (r < 78) return CH_SPACE;
        if (r < 84) return $urandom_range(0, 1) ? CH_PLUS : CH_MINUS;
        return 8'($urandom_range(0, 255));
    endfunction

    // one cue frame, mostly well formed, then end of cue
    task automatic add_random_frame();
        logic [7:0] body[$];
        logic [23:0] ty;
        int r, ev;
        case ($urandom_range(0, 9))
            0, 1, 2: ty = TYPE_MOTOR;
            3, 4, 5: ty = TYPE_RELAY;
            6, 7, 8: ty = TYPE_LIGHT;
            default: ty = {8'($urandom_range(65, 90)), 8'($urandom_range(65, 90)),
                           8'($urandom_range(65, 90))};
        endcase
        body.push_back(($urandom_range(0, 99) < 92) ? CH_START : 8'($urandom_range(0, 255)));
        repeat (5) body.push_back(8'($urandom_range(0, 255)));
        for (int i = 16; i >= 0; i -= 8) body.push_back(ty[i+:8]);
        // small device numbers so that relays land in range often
        if ($urandom_range(0, 1) == 1) begin
            body.push_back($urandom_range(0, 1) ? CH_ZERO : CH_SPACE);
            body.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
        end else begin
            repeat (2) body.push_back(num_char());
        end
        if ($urandom_range(0, 4) == 0) repeat (3) body.push_back(CH_ZERO);
        else repeat (3) body.push_back(num_char());
        repeat (5) body.push_back(num_char());
        body.push_back(($urandom_range(0, 99) < 92) ? CH_END : 8'($urandom_range(0, 255)));
        // short and overlong frames
        r = $urandom_range(0, 99);
        if (r < 8) repeat ($urandom_range(1, 19)) void'(body.pop_back());
        else if (r < 16) repeat ($urandom_range(1, 15)) body.push_back(8'($urandom_range(0, 255)));
        // stop or restart inside a frame
        ev = ($urandom_range(0, 19) == 0) ? $urandom_range(0, body.size() - 1) : -1;
        for (int i = 0; i < body.size(); i++) begin
            if (i == ev)
                add_item($urandom_range(0, 1) ? OP_STOP : OP_RESTART, 8'($urandom_range(0, 255)));
            add_item(OP_CHAR, body[i]);
        end
        add_item(OP_END, 8'($urandom_range(0, 255)));
    endtask

    task automatic add_random_step();
        int r;
        r = $urandom_range(0, 99);
        if (r < 6) add_item(opcode_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
        else if (r < 12) add_item(OP_STOP, 8'($urandom_range(0, 255)));
        else if (r < 22) add_item(OP_RESTART, 8'($urandom_range(0, 255)));
        else add_random_frame();
    endtask

    // wait until every item is taken and every result checked, then settle
    task automatic drain();
        @(negedge aclk);
        while (items_taken != items_sent || dispatch_q.size() != 0) @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
    endtask

    task automatic cfg_write(int value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= CHAN_W'(value);
        @(negedge aclk);
        while (!cfg_hs) @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // stimulus
    initial begin
        string cue;
        int target;
        int setting;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // events, a short frame of extreme bytes, then a valid motor cue with device 99 and percent 999
        add_item(OP_STOP, 8'hFF);
        add_item(OP_RESTART, 8'h00);
        add_item(OP_CHAR, 8'h00);
        add_item(OP_CHAR, 8'hFF);
        add_item(OP_END, 8'hA5);
        cue = "$12345MOT99999 0000%";
        for (int i = 0; i < cue.len(); i++) add_item(OP_CHAR, cue[i]);
        add_item(OP_END, 8'h5A);
        drain();

        // random phases, each under a new channel count
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: setting = 1;
                1: setting = 512;
                default: setting = $urandom_range(1, 100);
            endcase
            cfg_write(setting);
            target = items_sent + PHASE_ITEMS;
            while (items_sent < target) add_random_step();
            drain();
        end

        if (errors == 0) begin
            $display("cue_frame_parser_dispatch: match");
        end else begin
            $display("cue_frame_parser_dispatch: mismatch");
        end
        $finish;
    end

endmodule
